[rtl/core/skt_pkg.sv]
// shared types and constants of the sorted key table
package skt_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned ROW_W    = 64;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LIMIT_W  = 9;
  localparam int unsigned CNT_W    = 9;

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_FULL      = 3'd2,
    STS_DUPLICATE = 3'd3,
    STS_RANGE     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;
    logic rd_cmd;
    logic ins_en;
    logic del_en;
  } cell_ctrl_t;

endpackage

[rtl/core/skt_cell.sv]
// one entry of the sorted table: compare against the command key and shift
module skt_cell import skt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic             valid_i,
  input  logic             pos_hit_i,
  input  logic [KEY_W-1:0] cmd_key_i,
  input  logic [ROW_W-1:0] cmd_row_i,
  input  logic             lt_prev_i,
  input  logic [KEY_W-1:0] left_key_i,
  input  logic [ROW_W-1:0] left_row_i,
  input  logic [KEY_W-1:0] right_key_i,
  input  logic [ROW_W-1:0] right_row_i,
  output logic [KEY_W-1:0] key_o,
  output logic [ROW_W-1:0] row_o,
  output logic             lt_o,
  output logic             eq_o,
  output logic [KEY_W-1:0] sel_key_o,
  output logic [ROW_W-1:0] sel_row_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             lt_q, eq_q, sel_q;
  logic             lt_d, eq_d, sel_d;

  // compare phase: ordering and match flags of this entry
  always_comb begin
    lt_d  = lt_q;
    eq_d  = eq_q;
    sel_d = sel_q;
    if (ctrl_i.cmp_en) begin
      lt_d  = valid_i && (key_q < cmd_key_i);
      eq_d  = valid_i && (key_q == cmd_key_i);
      sel_d = ctrl_i.rd_cmd ? (valid_i && pos_hit_i) : (valid_i && (key_q == cmd_key_i));
    end
  end

  // update phase: open a gap for insert or close one for delete
  always_comb begin
    key_d = key_q;
    row_d = row_q;
    if (ctrl_i.ins_en) begin
      if (!lt_prev_i) begin
        key_d = left_key_i;
        row_d = left_row_i;
      end else if (!lt_q) begin
        key_d = cmd_key_i;
        row_d = cmd_row_i;
      end
    end else if (ctrl_i.del_en && !lt_q) begin
      key_d = right_key_i;
      row_d = right_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q  <= 1'b0;
      eq_q  <= 1'b0;
      sel_q <= 1'b0;
    end else begin
      lt_q  <= lt_d;
      eq_q  <= eq_d;
      sel_q <= sel_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    row_q <= row_d;
  end

  assign key_o     = key_q;
  assign row_o     = row_q;
  assign lt_o      = lt_q;
  assign eq_o      = eq_q;
  assign sel_key_o = sel_q ? key_q : '0;
  assign sel_row_o = sel_q ? row_q : '0;

endmodule

[rtl/core/sorted_key_table_core.sv]
// top level of the sorted key table: command sequencer, count and cell chain
//
// A table of unique 32-bit keys with 64-bit row identifiers, kept in ascending
// key order in a chain of CAPACITY cells. A command is taken when start_i is
// high and busy_o is low. Each command has a compare state, where every cell
// compares its key with the command key at once, and an update state, where
// the chain shifts by one place (insert, delete) and the result is selected.
// done_o, registered from the update state, pulses for exactly one cycle with
// status, found key and row, and the entry count; the receiver cannot hold it
// off. busy_o is high only in the compare state, so a new command is taken
// during the previous one's update state. max_entries must be written through
// cfg_we_i/cfg_wdata_i while no command runs; the block does not enforce it.
module sorted_key_table_core import skt_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          command_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [ROW_W-1:0]    row_ref_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic                cfg_we_i,
  input  logic [LIMIT_W-1:0]  cfg_wdata_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [KEY_W-1:0]    found_key_o,
  output logic [ROW_W-1:0]    found_row_o,
  output logic [CNT_W-1:0]    entry_count_o
);

  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned LW0 = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int unsigned LW  = (LW0 > POS_W) ? LW0 : POS_W;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  state_e state_q, state_d;
  logic   accept, cmp_en, upd_en;

  cmd_e             cmd_q;
  logic [KEY_W-1:0] cmd_key_q;
  logic [ROW_W-1:0] cmd_row_q;
  logic [POS_W-1:0] cmd_pos_q;

  logic [CW-1:0]      count_q, count_d;
  logic [LIMIT_W-1:0] max_q;

  logic [KEY_W-1:0] cell_key [CAPACITY];
  logic [ROW_W-1:0] cell_row [CAPACITY];
  logic [KEY_W-1:0] sel_key  [CAPACITY];
  logic [ROW_W-1:0] sel_row  [CAPACITY];
  logic [CAPACITY-1:0] lt_w, eq_w;

  cell_ctrl_t ctrl;
  logic       hit, full, in_range, ins_ok, del_ok;
  logic [LW-1:0] limit;
  logic [KEY_W-1:0] or_key;
  logic [ROW_W-1:0] or_row;

  logic                done_q;
  status_e             status_q, status_d;
  logic [KEY_W-1:0]    fkey_q, fkey_d;
  logic [ROW_W-1:0]    frow_q, frow_d;

  assign accept = start_i && !busy_o;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  state_d = start_i ? ST_CMP : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy_o = 1'b0;
    cmp_en = 1'b0;
    upd_en = 1'b0;
    case (state_q)
      ST_CMP: begin
        busy_o = 1'b1;
        cmp_en = 1'b1;
      end
      ST_UPD:  upd_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // command transaction capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_e'(command_i);
      cmd_key_q <= key_i;
      cmd_row_q <= row_ref_i;
      cmd_pos_q <= position_i;
    end
  end

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= LIMIT_W'(256);
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  // match and selection reduction across the chain
  always_comb begin
    hit    = |eq_w;
    or_key = '0;
    or_row = '0;
    for (int unsigned j = 0; j < CAPACITY; j++) begin
      or_key = or_key | sel_key[j];
      or_row = or_row | sel_row[j];
    end
  end

  // command decisions in the update cycle
  always_comb begin
    limit    = (LW'(max_q) > CAP_L) ? CAP_L : LW'(max_q);
    full     = LW'(count_q) >= limit;
    in_range = LW'(cmd_pos_q) < LW'(count_q);
    ins_ok   = upd_en && (cmd_q == CMD_INSERT) && !full && !hit;
    del_ok   = upd_en && (cmd_q == CMD_DELETE) && hit;

    ctrl.cmp_en = cmp_en;
    ctrl.rd_cmd = (cmd_q == CMD_READ);
    ctrl.ins_en = ins_ok;
    ctrl.del_en = del_ok;

    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CW'(1);
    end else if (del_ok) begin
      count_d = count_q - CW'(1);
    end

    status_d = STS_OK;
    fkey_d   = '0;
    frow_d   = '0;
    case (cmd_q)
      CMD_FIND: begin
        if (hit) begin
          fkey_d = or_key;
          frow_d = or_row;
        end else begin
          status_d = STS_NOT_FOUND;
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status_d = STS_FULL;
        end else if (hit) begin
          status_d = STS_DUPLICATE;
        end
      end
      CMD_DELETE: begin
        if (!hit) status_d = STS_NOT_FOUND;
      end
      CMD_READ: begin
        if (in_range) begin
          fkey_d = or_key;
          frow_d = or_row;
        end else begin
          status_d = STS_RANGE;
        end
      end
      default: status_d = STS_OK;
    endcase
  end

  // count and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= upd_en;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (upd_en) begin
      status_q <= status_d;
      fkey_q   <= fkey_d;
      frow_q   <= frow_d;
    end
  end

  // chain of cells
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    localparam logic [LW-1:0] IDX = LW'(j);
    logic             valid, pos_hit, lt_prev;
    logic [KEY_W-1:0] left_key, right_key;
    logic [ROW_W-1:0] left_row, right_row;

    assign valid   = IDX < LW'(count_q);
    assign pos_hit = LW'(cmd_pos_q) == IDX;

    if (j == 0) begin : g_head
      assign lt_prev  = 1'b1;
      assign left_key = '0;
      assign left_row = '0;
    end else begin : g_body
      assign lt_prev  = lt_w[j-1];
      assign left_key = cell_key[j-1];
      assign left_row = cell_row[j-1];
    end

    if (j == CAPACITY - 1) begin : g_tail
      assign right_key = '0;
      assign right_row = '0;
    end else begin : g_next
      assign right_key = cell_key[j+1];
      assign right_row = cell_row[j+1];
    end

    skt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .valid_i     (valid),
      .pos_hit_i   (pos_hit),
      .cmd_key_i   (cmd_key_q),
      .cmd_row_i   (cmd_row_q),
      .lt_prev_i   (lt_prev),
      .left_key_i  (left_key),
      .left_row_i  (left_row),
      .right_key_i (right_key),
      .right_row_i (right_row),
      .key_o       (cell_key[j]),
      .row_o       (cell_row[j]),
      .lt_o        (lt_w[j]),
      .eq_o        (eq_w[j]),
      .sel_key_o   (sel_key[j]),
      .sel_row_o   (sel_row[j])
    );
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_key_o   = fkey_q;
  assign found_row_o   = frow_q;
  assign entry_count_o = CNT_W'(count_q);

  // every accepted command leads to a result strobe on done_o
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##2 done_o) else $error("result strobe missing after command");

  // the compare cycle lasts exactly one cycle
  a_busy_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o) else $error("busy held longer than one cycle");

  // count never exceeds the chain length
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(count_q) <= CAP_L) else $error("entry count above capacity");

  // count stays unchanged outside the update state
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_en |=> $stable(count_q)) else $error("count changed outside update");

endmodule
